[rtl/core/sobel_pkg.sv]
// sobel_pkg: shared widths, register indexes and pipeline structs for the
// 3x3 sobel edge magnitude core. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sobel_pkg;

  localparam int unsigned MaxLineWidth = 1024;
  localparam int unsigned ColW         = $clog2(MaxLineWidth);
  localparam int unsigned LwW          = $clog2(MaxLineWidth + 1);
  localparam int unsigned RowW         = 12;
  localparam int unsigned FhW          = 12;
  localparam int unsigned PixW         = 8;
  localparam int unsigned SumW         = PixW + 2;
  localparam int unsigned GradW        = PixW + 3;
  localparam int unsigned CfgIdxW      = 1;
  localparam int unsigned CfgDataW     = 12;

  typedef enum logic [CfgIdxW-1:0] {
    CfgLineWidth   = 1'b0,
    CfgFrameHeight = 1'b1
  } cfg_idx_e;

  // position of the window centre that goes with one pixel
  typedef struct packed {
    logic [ColW-1:0] col;
    logic [RowW-1:0] row;
    logic            last;
    logic            emit;
  } pos_t;

  // one new window column: two rows from the line memory plus the new pixel
  typedef struct packed {
    logic [PixW-1:0] top;
    logic [PixW-1:0] mid;
    logic [PixW-1:0] bot;
  } column_t;

endpackage

`default_nettype wire

[rtl/core/sobel_pix_if.sv]
// sobel_pix_if: pixel input channel, valid/ready with pixel and frame start.
// Depends on sobel_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface sobel_pix_if import sobel_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [PixW-1:0] pixel;
  logic            start_of_frame;

  modport source (output valid, output pixel, output start_of_frame, input ready);
  modport sink   (input valid, input pixel, input start_of_frame, output ready);
endinterface

`default_nettype wire

[rtl/core/sobel_res_if.sv]
// sobel_res_if: result channel, valid/ready with magnitude, centre position
// and last-of-frame flag. Depends on sobel_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface sobel_res_if import sobel_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [PixW-1:0] magnitude;
  logic [ColW-1:0] centre_col;
  logic [RowW-1:0] centre_row;
  logic            frame_last;

  modport source (output valid, output magnitude, output centre_col,
                  output centre_row, output frame_last, input ready);
  modport sink   (input valid, input magnitude, input centre_col,
                  input centre_row, input frame_last, output ready);
endinterface

`default_nettype wire

[rtl/core/sobel_pos.sv]
// sobel_pos: configuration registers and raster position counters; tags each
// accepted pixel with its line memory index and window centre. Uses sobel_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sobel_pos import sobel_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                acc_i,
  input  logic                sof_i,
  output logic [ColW-1:0]     idx_o,
  output pos_t                pos_o
);

  logic [LwW-1:0]  lw_q;
  logic [FhW-1:0]  fh_q;
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;

  logic [LwW-1:0]  w;
  logic [FhW-1:0]  h;
  logic [ColW-1:0] c;
  logic [RowW-1:0] r;
  logic [LwW-1:0]  col_inc;
  logic [RowW:0]   row_inc;

  always_comb begin
    // out-of-range sizes are clamped
    if (lw_q < LwW'(3)) begin
      w = LwW'(3);
    end else if (lw_q > LwW'(MaxLineWidth)) begin
      w = LwW'(MaxLineWidth);
    end else begin
      w = lw_q;
    end
    h = (fh_q < FhW'(3)) ? FhW'(3) : fh_q;

    c = sof_i ? '0 : col_q;
    r = sof_i ? '0 : row_q;
    col_inc = LwW'(c) + LwW'(1);
    row_inc = (RowW + 1)'(r) + (RowW + 1)'(1);

    idx_o         = c;
    pos_o.col     = c - ColW'(1);
    pos_o.row     = r - RowW'(1);
    pos_o.emit    = (r >= RowW'(2)) && (c >= ColW'(2));
    pos_o.last    = (LwW'(c) == w - LwW'(1)) && (r == RowW'(h - FhW'(1)));

    col_d = col_q;
    row_d = row_q;
    if (acc_i) begin
      if (col_inc >= w) begin
        col_d = '0;
        row_d = (row_inc >= (RowW + 1)'(h)) ? '0 : row_inc[RowW-1:0];
      end else begin
        col_d = col_inc[ColW-1:0];
        row_d = r;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_q  <= LwW'(640);
      fh_q  <= FhW'(480);
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CfgLineWidth:   lw_q <= cfg_data_i[LwW-1:0];
          CfgFrameHeight: fh_q <= cfg_data_i[FhW-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/sobel_line_buf.sv]
// sobel_line_buf: both line stores in one 16-bit wide synchronous memory,
// read at accept and written back one stage later, with same-entry forwarding.
// Uses sobel_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sobel_line_buf import sobel_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [PixW-1:0] px_i,
  input  logic [ColW-1:0] idx_i,
  input  pos_t            pos_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output column_t         column_o,
  output pos_t            pos_o
);

  // entry = {upper row, middle row}
  logic [2*PixW-1:0] mem [MaxLineWidth];

  logic              v1_q;
  logic [PixW-1:0]   px1_q;
  logic [ColW-1:0]   idx1_q;
  pos_t              pos1_q;
  logic [2*PixW-1:0] rd_q;
  logic              fwd_q;
  logic [2*PixW-1:0] fwd_data_q;

  logic              acc, adv;
  logic [2*PixW-1:0] rd_eff, wdata;

  assign acc        = in_valid_i & in_ready_o;
  assign adv        = v1_q & out_ready_i;
  assign in_ready_o = ~v1_q | out_ready_i;

  // a write-back on the same edge as the read of the same entry is forwarded
  assign rd_eff = fwd_q ? fwd_data_q : rd_q;
  assign wdata  = {rd_eff[PixW-1:0], px1_q};

  assign column_o.top = rd_eff[2*PixW-1:PixW];
  assign column_o.mid = rd_eff[PixW-1:0];
  assign column_o.bot = px1_q;
  assign pos_o        = pos1_q;
  assign out_valid_o  = v1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mem[idx1_q] <= wdata;
    end
    if (acc) begin
      rd_q <= mem[idx_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      px1_q      <= px_i;
      idx1_q     <= idx_i;
      pos1_q     <= pos_i;
      fwd_q      <= adv && (idx1_q == idx_i);
      fwd_data_q <= wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (acc) begin
      v1_q <= 1'b1;
    end else if (adv) begin
      v1_q <= 1'b0;
    end
  end

endmodule

`default_nettype wire

[rtl/core/sobel_grad.sv]
// sobel_grad: 3x3 window register, gradient stage and magnitude output
// register, each with its own valid bit. Uses sobel_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sobel_grad import sobel_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  column_t         column_i,
  input  pos_t            pos_i,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output logic [PixW-1:0] mag_o,
  output pos_t            pos_o
);

  // win_q[0] oldest column, win_q[2] newest
  column_t                  win_q [3];
  logic                     v2_q, v3_q, vo_q;
  pos_t                     pos2_q, pos3_q, poso_q;
  logic signed [GradW-1:0]  gx_q, gy_q;
  logic [PixW-1:0]          mag_q;

  logic                     acc, rdy2, rdy3, rdy4, adv2, adv3;
  logic [SumW-1:0]          s_right, s_left, s_bot, s_top;
  logic signed [GradW-1:0]  gx_d, gy_d;
  logic [GradW-1:0]         ax, ay, mag_sum;
  logic [PixW-1:0]          mag_d;

  assign rdy4       = ~vo_q | res_ready_i;
  assign rdy3       = ~v3_q | rdy4;
  assign rdy2       = ~v2_q | rdy3;
  assign adv3       = v3_q & rdy4;
  assign adv2       = v2_q & rdy3;
  assign in_ready_o = rdy2;
  assign acc        = in_valid_i & rdy2;

  always_comb begin
    s_right = SumW'(win_q[2].top) + {1'b0, win_q[2].mid, 1'b0} + SumW'(win_q[2].bot);
    s_left  = SumW'(win_q[0].top) + {1'b0, win_q[0].mid, 1'b0} + SumW'(win_q[0].bot);
    s_bot   = SumW'(win_q[0].bot) + {1'b0, win_q[1].bot, 1'b0} + SumW'(win_q[2].bot);
    s_top   = SumW'(win_q[0].top) + {1'b0, win_q[1].top, 1'b0} + SumW'(win_q[2].top);
    gx_d    = $signed({1'b0, s_right}) - $signed({1'b0, s_left});
    gy_d    = $signed({1'b0, s_bot}) - $signed({1'b0, s_top});

    ax      = gx_q[GradW-1] ? GradW'(-gx_q) : GradW'(gx_q);
    ay      = gy_q[GradW-1] ? GradW'(-gy_q) : GradW'(gy_q);
    mag_sum = ax + ay;
    // saturate at full scale
    mag_d   = (|mag_sum[GradW-1:PixW]) ? '1 : mag_sum[PixW-1:0];
  end

  // every pixel shifts the window, only interior ones go on
  always_ff @(posedge clk_i) begin
    if (acc) begin
      win_q[0] <= win_q[1];
      win_q[1] <= win_q[2];
      win_q[2] <= column_i;
      pos2_q   <= pos_i;
    end
    if (adv2) begin
      gx_q   <= gx_d;
      gy_q   <= gy_d;
      pos3_q <= pos2_q;
    end
    if (adv3) begin
      mag_q  <= mag_d;
      poso_q <= pos3_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (acc) begin
        v2_q <= pos_i.emit;
      end else if (adv2) begin
        v2_q <= 1'b0;
      end
      if (adv2) begin
        v3_q <= 1'b1;
      end else if (adv3) begin
        v3_q <= 1'b0;
      end
      if (adv3) begin
        vo_q <= 1'b1;
      end else if (res_ready_i) begin
        vo_q <= 1'b0;
      end
    end
  end

  assign res_valid_o = vo_q;
  assign mag_o       = mag_q;
  assign pos_o       = poso_q;

endmodule

`default_nettype wire

[rtl/core/sobel_edge_magnitude_3x3_core.sv]
// Sobel 3x3 edge magnitude core: takes one grayscale pixel per clock in raster
// order, unless the output stalls, and gives min(|gx|+|gy|, 255) for every
// interior pixel, tagged with the centre row, column and a last-of-frame flag.
// A pixel can be accepted every clock while nothing stalls; the line memory is
// a single 1024 x 16 synchronous RAM that is read when a pixel is accepted and
// written back one stage later, so one read and one write per pixel set that
// rate. A result passes the line buffer, window, gradient and magnitude output
// registers; each stage has its own valid bit, so input keeps flowing while a
// result waits until the stages fill. The line memory needs no clearing after
// reset; rows read before they were written never reach a result. Width and
// height registers should be written while idle. Depends on sobel_pkg,
// sobel_pix_if, sobel_res_if, sobel_pos, sobel_line_buf and sobel_grad.
`timescale 1ns / 1ps
`default_nettype none

module sobel_edge_magnitude_3x3_core import sobel_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  sobel_pix_if.sink           pix_i,
  sobel_res_if.source         res_o
);

  logic            lb_ready, lb_valid, gr_ready, acc;
  logic [ColW-1:0] idx;
  pos_t            pos_in, pos_lb, pos_out;
  column_t         column;

  assign acc         = pix_i.valid & lb_ready;
  assign pix_i.ready = lb_ready;

  sobel_pos u_pos (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .acc_i      (acc),
    .sof_i      (pix_i.start_of_frame),
    .idx_o      (idx),
    .pos_o      (pos_in)
  );

  sobel_line_buf u_line_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pix_i.valid),
    .in_ready_o  (lb_ready),
    .px_i        (pix_i.pixel),
    .idx_i       (idx),
    .pos_i       (pos_in),
    .out_valid_o (lb_valid),
    .out_ready_i (gr_ready),
    .column_o    (column),
    .pos_o       (pos_lb)
  );

  sobel_grad u_grad (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (lb_valid),
    .in_ready_o  (gr_ready),
    .column_i    (column),
    .pos_i       (pos_lb),
    .res_valid_o (res_o.valid),
    .res_ready_i (res_o.ready),
    .mag_o       (res_o.magnitude),
    .pos_o       (pos_out)
  );

  assign res_o.centre_col = pos_out.col;
  assign res_o.centre_row = pos_out.row;
  assign res_o.frame_last = pos_out.last;

endmodule

`default_nettype wire

[rtl/core/sobel_chk.sv]
// sobel_chk: port-level checks for the sobel core, bound to the top level.
// Depends on sobel_pkg and sobel_edge_magnitude_3x3_core.
`timescale 1ns / 1ps
`default_nettype none

module sobel_chk import sobel_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input logic [PixW-1:0] magnitude,
  input logic [ColW-1:0] centre_col,
  input logic [RowW-1:0] centre_row,
  input logic            frame_last
);

  // a result beat waits until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(magnitude) && $stable(centre_col)
      && $stable(centre_row) && $stable(frame_last))
    else $error("result payload changed while stalled");

  // no stall downstream means the pipe can take a pixel
  a_no_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready |-> in_ready)
    else $error("input stalled without output backpressure");

  // results only for interior centres
  a_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> centre_col != '0 && centre_row != '0 && centre_col != '1)
    else $error("result for a border pixel");

  logic unused_in_valid;
  assign unused_in_valid = in_valid;

endmodule

bind sobel_edge_magnitude_3x3_core sobel_chk u_sobel_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (pix_i.valid),
  .in_ready   (pix_i.ready),
  .out_valid  (res_o.valid),
  .out_ready  (res_o.ready),
  .magnitude  (res_o.magnitude),
  .centre_col (res_o.centre_col),
  .centre_row (res_o.centre_row),
  .frame_last (res_o.frame_last)
);

`default_nettype wire
